@@ design/lfcc_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lfcc_pkg: shared types and constants of the LED frame command controller
// Command codes, status codes, store geometry and sequencer states.
// ---------------------------------------------------------------------------
package lfcc_pkg;

  localparam int unsigned LedCount   = 88;
  localparam int unsigned ChunkLeds  = 9;
  localparam int unsigned BatchLimit = 9;
  localparam int unsigned ChunkTotal = (LedCount + ChunkLeds - 1) / ChunkLeds;
  localparam int unsigned AddrW      = $clog2(LedCount);
  localparam int unsigned ColorW     = 24;
  localparam int unsigned TickW      = 18;
  localparam logic [TickW-1:0] TickMax = '1;
  localparam logic [15:0] ChunksFull =
      (ChunkTotal >= 16) ? 16'hFFFF : 16'((32'd1 << ChunkTotal) - 32'd1);

  localparam logic [7:0]  DefTimeoutRst = 8'd30;
  localparam logic [7:0]  MaxTimeoutRst = 8'd255;
  localparam logic [15:0] TicksRst      = 16'd1000;
  localparam logic [7:0]  VersionRst    = 8'd1;

  typedef enum logic [3:0] {
    CMD_ENABLE  = 4'd0,
    CMD_DISABLE = 4'd1,
    CMD_ALL     = 4'd2,
    CMD_ONE     = 4'd3,
    CMD_BATCH   = 4'd4,
    CMD_FRAME   = 4'd5,
    CMD_HEART   = 4'd6,
    CMD_PING    = 4'd7,
    CMD_READ    = 4'd8,
    CMD_TICK    = 4'd9
  } cmd_e;

  typedef enum logic [1:0] {
    ST_ACK  = 2'd0,
    ST_NACK = 2'd1,
    ST_PONG = 2'd2,
    ST_DATA = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_DEF_TIMEOUT = 2'd0,
    REG_MAX_TIMEOUT = 2'd1,
    REG_TICKS       = 2'd2,
    REG_VERSION     = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WRITE,
    S_COPY_RD,
    S_COPY_WR,
    S_READ,
    S_TICK,
    S_DONE
  } state_e;

  // What the sequencer asks of the store walker for one step
  typedef struct packed {
    logic              stg_we;
    logic              live_we;
    logic [AddrW-1:0]  stg_addr;
    logic [AddrW-1:0]  live_addr;
    logic [AddrW-1:0]  stg_raddr;
    logic [ColorW-1:0] stg_wdata;
    logic              live_from_stg;
  } store_ctrl_t;

endpackage
`default_nettype wire

@@ design/lfcc_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lfcc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module lfcc_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 88
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ design/lfcc_stores.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lfcc_stores: staging and live color stores
// Live writes take either staging read data (copy) or the given color.
// ---------------------------------------------------------------------------
module lfcc_stores (
  input  wire                          clk_i,
  input  wire lfcc_pkg::store_ctrl_t   ctrl_i,
  input  wire [lfcc_pkg::AddrW-1:0]    live_raddr_i,
  output logic [lfcc_pkg::ColorW-1:0]  live_rdata_o
);
  import lfcc_pkg::*;

  logic [ColorW-1:0] stg_rdata;
  logic [ColorW-1:0] live_wdata;

  assign live_wdata = ctrl_i.live_from_stg ? stg_rdata : ctrl_i.stg_wdata;

  lfcc_ram #(.Width(ColorW), .Depth(LedCount)) u_stg (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.stg_we),
    .waddr_i (ctrl_i.stg_addr),
    .wdata_i (ctrl_i.stg_wdata),
    .raddr_i (ctrl_i.stg_raddr),
    .rdata_o (stg_rdata)
  );

  lfcc_ram #(.Width(ColorW), .Depth(LedCount)) u_live (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.live_we),
    .waddr_i (ctrl_i.live_addr),
    .wdata_i (live_wdata),
    .raddr_i (live_raddr_i),
    .rdata_o (live_rdata_o)
  );
endmodule
`default_nettype wire

@@ design/led_frame_command_controller_unit.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// led_frame_command_controller_unit: host command engine for an LED store
// Sequencer walking a staging and a live store through an address counter and a color counter.
// ---------------------------------------------------------------------------
// Channel | Dir | Handshake          | Payload
// s_axis  | in  | tvalid/tready      | tdata: command, param_a, param_b, color_0..8
// m_axis  | out | tvalid/tready      | tdata: status, version, is_active, led_total,
//         |     |                    |        read_color
// cfg     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Steps after the input transfer, up to the result: enable clears both stores
// in one pass; set all fills staging, then copies staging to live, reading and
// writing each entry in turn; set one, batch and chunk writes put their colors
// in staging, then run the copy when they publish. Tick registers the multiply,
// then compares, and gives no result.
// After reset a clearing pass zeroes both stores; no input meanwhile.
// A result holds in the output register until taken; no new item meanwhile.
// ---------------------------------------------------------------------------
module led_frame_command_controller_unit (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // command[3:0], param_a[11:4], param_b[19:12], color_0..color_8 [235:20]
  input  wire  [239:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // status[1:0], version[9:2], is_active[10], led_total[18:11], read_color[42:19]
  output logic [47:0]  m_axis_tdata,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [1:0]   cfg_index,
  input  wire  [15:0]  cfg_data
);
  import lfcc_pkg::*;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(LedCount - 1);

  state_e state_q, state_d;

  logic [3:0]        cmd_q;
  logic [7:0]        pa_q, pb_q;
  logic [ColorW-1:0] col_q [9];

  logic [7:0]  def_to_q, max_to_q, ver_q;
  logic [15:0] tps_q;

  logic             active_q;
  logic [7:0]       timeout_q;
  logic [TickW-1:0] ticks_q;
  logic [7:0]       seq_q;
  logic [15:0]      rcv_q, exp_q;
  logic [23:0]      limit_q;

  logic [AddrW-1:0] addr_q;
  logic [3:0]       cnt_q;   // colors written so far in one/batch/chunk
  logic [3:0]       wlen_q;  // colors to write
  logic [AddrW:0]   base_q;
  logic             clear_q; // walk fills staging with one color (set all) or zeroes both stores
  logic             pub_q;   // publish after write phase
  logic             ok_q;
  logic             init_q;  // clearing pass after reset, no result

  logic [1:0]        ost_q;
  logic [ColorW-1:0] ocol_q;
  logic              ovalid_q;

  store_ctrl_t       sc;
  logic [ColorW-1:0] live_rdata;
  logic [AddrW-1:0]  live_raddr;

  assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {5'd0, ocol_q,
                          (ost_q == ST_PONG) ? 8'(LedCount) : 8'd0,
                          active_q,
                          (ost_q == ST_PONG) ? ver_q : 8'd0,
                          ost_q};

  wire in_xfer = s_axis_tvalid && s_axis_tready;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_to_q <= DefTimeoutRst;
      max_to_q <= MaxTimeoutRst;
      tps_q    <= TicksRst;
      ver_q    <= VersionRst;
    end else if (cfg_valid) begin
      case (reg_e'(cfg_index))
        REG_DEF_TIMEOUT: def_to_q <= cfg_data[7:0];
        REG_MAX_TIMEOUT: max_to_q <= cfg_data[7:0];
        REG_TICKS:       tps_q    <= cfg_data;
        REG_VERSION:     ver_q    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_xfer) state_d = S_DECODE;
      S_DECODE: begin
        case (cmd_e'(cmd_q))
          CMD_TICK:  state_d = active_q ? S_TICK : S_IDLE;
          CMD_READ:  state_d = S_READ;
          CMD_ENABLE: state_d = S_COPY_WR;
          CMD_ALL, CMD_ONE, CMD_BATCH, CMD_FRAME:
            state_d = active_q ? S_WRITE : S_DONE;
          default:   state_d = S_DONE;
        endcase
      end
      S_WRITE: begin
        if (!ok_q) state_d = S_DONE;
        else if (clear_q ? (addr_q == LastAddr) : (cnt_q >= wlen_q))
          state_d = pub_q ? S_COPY_RD : S_DONE;
      end
      S_COPY_RD: state_d = S_COPY_WR;
      S_COPY_WR: begin
        if (addr_q == LastAddr) state_d = init_q ? S_IDLE : S_DONE;
        else if (!clear_q) state_d = S_COPY_RD;
      end
      S_READ:  state_d = S_DONE;
      S_TICK:  state_d = S_IDLE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // store control
  always_comb begin
    sc = '0;
    sc.stg_raddr = addr_q;
    sc.stg_addr  = addr_q;
    sc.live_addr = addr_q;
    live_raddr   = pa_q[AddrW-1:0];
    case (state_q)
      S_WRITE: begin
        if (ok_q) begin
          sc.stg_we = clear_q || (cnt_q < wlen_q);
          sc.stg_wdata = clear_q ? col_q[0] : col_q[cnt_q];
          if (!clear_q) sc.stg_addr = AddrW'(base_q + (AddrW+1)'(cnt_q));
        end
      end
      S_COPY_WR: begin
        sc.live_we = 1'b1;
        sc.live_from_stg = !clear_q;
        sc.stg_we = clear_q;
        sc.stg_wdata = '0;
      end
      default: ;
    endcase
  end

  lfcc_stores u_stores (
    .clk_i        (clk_i),
    .ctrl_i       (sc),
    .live_raddr_i (live_raddr),
    .live_rdata_o (live_rdata)
  );

  logic [15:0] rcv_new;
  logic [7:0]  bsum;
  always_comb begin
    rcv_new = (seq_q != pa_q) ? 16'd0 : rcv_q;
    if (pb_q < 8'd16) rcv_new = rcv_new | (16'd1 << pb_q[3:0]);
    bsum = 8'(pa_q + pb_q);
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q <= s_axis_tdata[3:0];
      pa_q  <= s_axis_tdata[11:4];
      pb_q  <= s_axis_tdata[19:12];
      for (int i = 0; i < 9; i++) col_q[i] <= s_axis_tdata[20 + 24*i +: 24];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_COPY_WR;
      active_q  <= 1'b0;
      timeout_q <= DefTimeoutRst;
      ticks_q   <= '0;
      seq_q     <= '0;
      rcv_q     <= '0;
      exp_q     <= '0;
      limit_q   <= '0;
      addr_q    <= '0;
      cnt_q     <= '0;
      wlen_q    <= '0;
      base_q    <= '0;
      clear_q   <= 1'b1;
      pub_q     <= 1'b0;
      ok_q      <= 1'b0;
      init_q    <= 1'b1;
      ost_q     <= ST_ACK;
      ocol_q    <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          addr_q <= '0;
          cnt_q  <= '0;
        end
        S_DECODE: begin
          ost_q   <= ST_ACK;
          ocol_q  <= '0;
          clear_q <= 1'b0;
          pub_q   <= 1'b1;
          ok_q    <= 1'b1;
          limit_q <= 24'(timeout_q) * 24'(tps_q);
          case (cmd_e'(cmd_q))
            CMD_ENABLE: begin
              active_q  <= 1'b1;
              timeout_q <= (pa_q != 8'd0 && pa_q <= max_to_q) ? pa_q : def_to_q;
              ticks_q   <= '0;
              seq_q     <= '0;
              rcv_q     <= '0;
              exp_q     <= ChunksFull;
              clear_q   <= 1'b1;
            end
            CMD_DISABLE: active_q <= 1'b0;
            CMD_PING:    ost_q <= ST_PONG;
            CMD_READ:    ost_q <= ST_DATA;
            CMD_TICK:    ;
            CMD_HEART:   begin
              if (active_q) ticks_q <= '0;
              else ost_q <= ST_NACK;
            end
            CMD_ALL: begin
              if (active_q) ticks_q <= '0; else ost_q <= ST_NACK;
              clear_q <= 1'b1;
            end
            CMD_ONE: begin
              if (active_q) ticks_q <= '0; else ost_q <= ST_NACK;
              ok_q   <= pa_q < 8'(LedCount);
              base_q <= (AddrW+1)'(pa_q);
              wlen_q <= 4'd1;
            end
            CMD_BATCH: begin
              if (active_q) ticks_q <= '0; else ost_q <= ST_NACK;
              ok_q   <= pb_q <= 8'(BatchLimit) && {1'b0, bsum} <= 9'(LedCount)
                        && pa_q <= 8'(LedCount);
              base_q <= (AddrW+1)'(pa_q);
              wlen_q <= pb_q[3:0];
            end
            CMD_FRAME: begin
              if (active_q) begin
                ticks_q <= '0;
                seq_q   <= pa_q;
                if (pb_q < 8'(ChunkTotal)) begin
                  base_q <= (AddrW+1)'(pb_q * ChunkLeds);
                  wlen_q <= (pb_q * ChunkLeds + ChunkLeds > LedCount)
                            ? 4'(LedCount - pb_q * ChunkLeds) : 4'(ChunkLeds);
                  if (rcv_new == exp_q) rcv_q <= '0;
                  else begin
                    rcv_q <= rcv_new;
                    pub_q <= 1'b0;
                  end
                end else begin
                  // new sequence still restarts the mask, no chunk bit
                  if (seq_q != pa_q) rcv_q <= '0;
                  ok_q  <= 1'b0;
                end
              end else ost_q <= ST_NACK;
            end
            default: ost_q <= ST_NACK;
          endcase
        end
        S_WRITE: begin
          if (!ok_q) ost_q <= ST_NACK;
          else if (clear_q) begin
            addr_q <= (addr_q == LastAddr) ? '0 : addr_q + 1'b1;
          end else if (cnt_q < wlen_q) cnt_q <= cnt_q + 1'b1;
          if (state_d == S_COPY_RD) clear_q <= 1'b0;
        end
        S_COPY_WR: begin
          if (addr_q != LastAddr) addr_q <= addr_q + 1'b1;
          else init_q <= 1'b0;
        end
        S_READ:  ocol_q <= (pa_q < 8'(LedCount)) ? live_rdata : '0;
        S_TICK: begin
          if ({6'd0, (ticks_q < TickMax) ? ticks_q + 1'b1 : ticks_q} > limit_q)
            active_q <= 1'b0;
          if (ticks_q < TickMax) ticks_q <= ticks_q + 1'b1;
        end
        S_DONE:  ovalid_q <= 1'b1;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> (state_q == S_IDLE && !ovalid_q))
    else $error("item accepted while busy");
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !m_axis_tready) |=> (ovalid_q && $stable(ost_q)))
    else $error("result dropped before transfer");
  a_enable_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECODE && cmd_q == CMD_ENABLE) |=> active_q)
    else $error("enable did not activate");
`endif
endmodule
`default_nettype wire

@@ tb/tb_led_frame_command_controller_unit.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_led_frame_command_controller_unit: self-checking bench of the LED command engine
// Directed table then random command streams over several register settings;
// every result is checked field by field against a table reply or an in-bench store model.
// ---------------------------------------------------------------------------
module tb_led_frame_command_controller_unit;
  import lfcc_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainWait  = 400;

  typedef struct {
    logic [3:0]  cmd;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [23:0] col [9];
  } host_cmd_t;

  typedef struct packed {
    logic [23:0] color;
    logic [7:0]  total;
    logic        act;
    logic [7:0]  ver;
    logic [1:0]  status;
  } reply_t;

  typedef struct {
    logic [3:0]  cmd;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [23:0] c0;
    logic        typed;
    reply_t      exp;
  } row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  wire          s_axis_tready;
  logic [239:0] s_axis_tdata = '0;
  wire          m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  wire  [47:0]  m_axis_tdata;
  logic         cfg_valid = 1'b0;
  wire          cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  always #1 clk_i = ~clk_i;

  led_frame_command_controller_unit u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // model state
  logic [23:0] stg_mem [LedCount];
  logic [23:0] live_mem [LedCount];
  logic        host_on;
  logic [7:0]  tmo_s;
  logic [17:0] idle_ticks;
  logic [7:0]  cur_seq;
  logic [15:0] chunk_seen;
  logic [15:0] chunk_full;
  logic [7:0]  def_tmo, max_tmo, ver_code;
  logic [15:0] tick_rate;

  reply_t      reply_q [$];
  host_cmd_t   cmd_q [$];
  int unsigned errors = 0, checked = 0, frames_done = 0, expiries = 0;
  logic        quiet = 1'b0;
  int unsigned stall_cnt = 0;
  int unsigned rx_hold = 0;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %0h expected %0h (reply %0d)", what, got, want, checked);
  endtask

  task automatic commit_frame();
    for (int i = 0; i < LedCount; i++) live_mem[i] = stg_mem[i];
  endtask

  // Advance the model by one command; has_reply is low for tick.
  task automatic predict_reply(input host_cmd_t c, output logic has_reply, output reply_t r);
    logic ok;
    logic [31:0] lim;
    int unsigned base, cnt;
    r = '0;
    has_reply = 1'b1;
    ok = 1'b0;
    if (c.cmd == CMD_TICK) begin
      has_reply = 1'b0;
      if (host_on) begin
        lim = 32'(tmo_s) * 32'(tick_rate);
        if (idle_ticks != TickMax) idle_ticks++;
        if (32'(idle_ticks) > lim) begin
          host_on = 1'b0;
          expiries++;
        end
      end
      return;
    end
    case (c.cmd)
      CMD_ENABLE: begin
        host_on = 1'b1;
        tmo_s = (c.a != 0 && c.a <= max_tmo) ? c.a : def_tmo;
        idle_ticks = '0;
        for (int i = 0; i < LedCount; i++) begin
          stg_mem[i] = '0;
          live_mem[i] = '0;
        end
        cur_seq = '0;
        chunk_seen = '0;
        chunk_full = (ChunkTotal >= 16) ? 16'hFFFF : 16'((1 << ChunkTotal) - 1);
        r.status = ST_ACK;
      end
      CMD_DISABLE: begin
        host_on = 1'b0;
        r.status = ST_ACK;
      end
      CMD_PING: begin
        r.status = ST_PONG;
        r.ver = ver_code;
        r.total = 8'(LedCount);
      end
      CMD_READ: begin
        r.status = ST_DATA;
        r.color = (c.a < LedCount) ? live_mem[c.a] : '0;
      end
      default: begin
        if (c.cmd > CMD_HEART || !host_on) begin
          r.status = ST_NACK;
        end else begin
          idle_ticks = '0;
          case (c.cmd)
            CMD_ALL: begin
              for (int i = 0; i < LedCount; i++) stg_mem[i] = c.col[0];
              commit_frame();
              ok = 1'b1;
            end
            CMD_ONE: if (c.a < LedCount) begin
              stg_mem[c.a] = c.col[0];
              commit_frame();
              ok = 1'b1;
            end
            CMD_BATCH: if (c.b <= BatchLimit && int'(c.a) + int'(c.b) <= LedCount) begin
              for (int i = 0; i < c.b; i++) stg_mem[c.a + i] = c.col[i];
              commit_frame();
              ok = 1'b1;
            end
            CMD_FRAME: begin
              if (c.a != cur_seq) begin
                cur_seq = c.a;
                chunk_seen = '0;
              end
              if (c.b < ChunkTotal) begin
                base = c.b * ChunkLeds;
                cnt = (base + ChunkLeds > LedCount) ? LedCount - base : ChunkLeds;
                for (int i = 0; i < cnt; i++) stg_mem[base + i] = c.col[i];
                if (c.b < 16) chunk_seen[c.b[3:0]] = 1'b1;
                if (chunk_seen == chunk_full) begin
                  commit_frame();
                  chunk_seen = '0;
                  frames_done++;
                end
                ok = 1'b1;
              end
            end
            default: ok = 1'b1; // heartbeat
          endcase
          r.status = ok ? ST_ACK : ST_NACK;
        end
      end
    endcase
    r.act = host_on;
  endtask

  function automatic host_cmd_t rand_cmd(logic [3:0] cmd);
    host_cmd_t c;
    c.cmd = cmd;
    c.a = 8'($urandom);
    c.b = 8'($urandom);
    for (int i = 0; i < 9; i++) c.col[i] = 24'($urandom);
    return c;
  endfunction

  // Mostly legal traffic: whole frames in shuffled order, small ranges, tick runs.
  task automatic gen_traffic(int unsigned n);
    host_cmd_t c;
    int unsigned k, order [ChunkTotal];
    logic [7:0] seq;
    while (n > 0) begin
      k = $urandom_range(0, 99);
      if (k < 25) begin
        seq = 8'($urandom);
        for (int i = 0; i < ChunkTotal; i++) order[i] = i;
        order.shuffle();
        for (int i = 0; i < ChunkTotal && n > 0; i++) begin
          if ($urandom_range(0, 19) == 0) continue; // drop a chunk
          c = rand_cmd(CMD_FRAME);
          c.a = ($urandom_range(0, 29) == 0) ? 8'($urandom) : seq;
          c.b = 8'(order[i]);
          cmd_q.push_back(c);
          n--;
        end
      end else if (k < 37) begin
        for (int i = $urandom_range(1, 6); i > 0 && n > 0; i--) begin
          cmd_q.push_back(rand_cmd(CMD_TICK));
          n--;
        end
      end else begin
        c = rand_cmd(4'($urandom_range(0, 15)));
        if (k < 45) c.cmd = CMD_READ;
        if (k < 42) c.cmd = CMD_ENABLE;
        if (c.cmd inside {CMD_ENABLE} && $urandom_range(0, 1)) c.a = 8'($urandom_range(0, 4));
        if (c.cmd inside {CMD_ONE, CMD_READ} && $urandom_range(0, 3) != 0)
          c.a = 8'($urandom_range(0, LedCount - 1));
        if (c.cmd == CMD_BATCH && $urandom_range(0, 3) != 0) begin
          c.b = 8'($urandom_range(0, BatchLimit));
          c.a = 8'($urandom_range(0, LedCount - c.b));
        end
        if (c.cmd == CMD_FRAME) c.b = 8'($urandom_range(0, ChunkTotal + 1));
        if (c.cmd == CMD_DISABLE && $urandom_range(0, 2) != 0) c.cmd = CMD_HEART;
        cmd_q.push_back(c);
        n--;
      end
    end
  endtask

  task automatic send_cmd(host_cmd_t c, logic typed, reply_t want);
    logic has;
    reply_t r;
    logic [239:0] d;
    d = {c.col[8], c.col[7], c.col[6], c.col[5], c.col[4], c.col[3], c.col[2],
         c.col[1], c.col[0], c.b, c.a, c.cmd};
    s_axis_tdata <= d;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_reply(c, has, r);
    if (has) reply_q.push_back(typed ? want : r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DEF_TIMEOUT: def_tmo = val[7:0];
      REG_MAX_TIMEOUT: max_tmo = val[7:0];
      REG_TICKS:       tick_rate = val;
      default:         ver_code = val[7:0];
    endcase
    @(posedge clk_i);
  endtask

  function automatic reply_t mk(status_e s, logic act, logic [7:0] v, logic [7:0] t,
                                logic [23:0] col);
    reply_t r;
    r.status = s;
    r.ver = v;
    r.act = act;
    r.total = t;
    r.color = col;
    return r;
  endfunction

  // receiver stalls: random bursts with tready low
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_hold <= 0;
    end else if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (rx_hold != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      rx_hold <= $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // scoreboard and watchdog
  always @(posedge clk_i) begin
    reply_t got, want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= StallLimit) begin
        $display("watchdog: no transfer for %0d cycles", StallLimit);
        $display("*** FAILED ***");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = reply_t'(m_axis_tdata[42:0]);
        if (reply_q.size() == 0) begin
          report("unexpected reply", 32'(m_axis_tdata), 0);
        end else begin
          want = reply_q.pop_front();
          if (got.status != want.status) report("status", got.status, want.status);
          if (got.ver != want.ver) report("version", got.ver, want.ver);
          if (got.act != want.act) report("is_active", got.act, want.act);
          if (got.total != want.total) report("led_total", got.total, want.total);
          if (got.color != want.color) report("read_color", got.color, want.color);
        end
        checked++;
      end
    end
  end

  row_t rows [$];

  initial begin
    host_cmd_t c;
    reply_t none;
    none = '0;
    def_tmo = DefTimeoutRst;
    max_tmo = MaxTimeoutRst;
    tick_rate = TicksRst;
    ver_code = VersionRst;
    for (int i = 0; i < LedCount; i++) begin
      stg_mem[i] = '0;
      live_mem[i] = '0;
    end
    host_on = 1'b0;
    tmo_s = DefTimeoutRst;
    idle_ticks = '0;
    cur_seq = '0;
    chunk_seen = '0;
    chunk_full = '0;

    rows = '{
      '{CMD_PING,    8'd0,   8'd0,  24'h0,      1, mk(ST_PONG, 0, 8'd1, 8'd88, 0)},
      '{CMD_ALL,     8'd0,   8'd0,  24'hFFFFFF, 1, mk(ST_NACK, 0, 0, 0, 0)},
      '{CMD_FRAME,   8'd1,   8'd0,  24'h123456, 1, mk(ST_NACK, 0, 0, 0, 0)},
      '{CMD_HEART,   8'd0,   8'd0,  24'h0,      1, mk(ST_NACK, 0, 0, 0, 0)},
      '{4'd15,       8'hFF,  8'hFF, 24'hFFFFFF, 1, mk(ST_NACK, 0, 0, 0, 0)},
      '{CMD_TICK,    8'd0,   8'd0,  24'h0,      0, none},
      '{CMD_DISABLE, 8'd0,   8'd0,  24'h0,      1, mk(ST_ACK, 0, 0, 0, 0)},
      '{CMD_ENABLE,  8'd0,   8'd0,  24'h0,      1, mk(ST_ACK, 1, 0, 0, 0)},
      '{CMD_READ,    8'd0,   8'd0,  24'h0,      1, mk(ST_DATA, 1, 0, 0, 0)},
      '{CMD_READ,    8'hFF,  8'd0,  24'h0,      1, mk(ST_DATA, 1, 0, 0, 0)},
      '{CMD_ALL,     8'd0,   8'd0,  24'hFFFFFF, 1, mk(ST_ACK, 1, 0, 0, 0)},
      '{CMD_READ,    8'd87,  8'd0,  24'h0,      1, mk(ST_DATA, 1, 0, 0, 24'hFFFFFF)},
      '{CMD_ONE,     8'd87,  8'd0,  24'hA5C3E1, 0, none},
      '{CMD_ONE,     8'd88,  8'd0,  24'h0,      1, mk(ST_NACK, 1, 0, 0, 0)},
      '{CMD_BATCH,   8'd79,  8'd9,  24'h000001, 0, none},
      '{CMD_BATCH,   8'd80,  8'd9,  24'h0,      1, mk(ST_NACK, 1, 0, 0, 0)},
      '{CMD_BATCH,   8'd0,   8'd10, 24'h0,      1, mk(ST_NACK, 1, 0, 0, 0)},
      '{CMD_BATCH,   8'd88,  8'd0,  24'h0,      0, none},
      '{CMD_FRAME,   8'd5,   8'd9,  24'h5A5A5A, 0, none},
      '{CMD_FRAME,   8'd5,   8'd10, 24'h0,      1, mk(ST_NACK, 1, 0, 0, 0)},
      '{CMD_FRAME,   8'd6,   8'd0,  24'h0F0F0F, 0, none},
      '{CMD_READ,    8'd81,  8'd0,  24'h0,      0, none},
      '{CMD_HEART,   8'd0,   8'd0,  24'h0,      1, mk(ST_ACK, 1, 0, 0, 0)},
      '{CMD_ENABLE,  8'hFF,  8'd0,  24'h0,      1, mk(ST_ACK, 1, 0, 0, 0)},
      '{CMD_DISABLE, 8'd0,   8'd0,  24'h0,      1, mk(ST_ACK, 0, 0, 0, 0)}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      c = rand_cmd(rows[i].cmd);
      c.a = rows[i].a;
      c.b = rows[i].b;
      c.col[0] = rows[i].c0;
      send_cmd(c, rows[i].typed, rows[i].exp);
    end
    settle();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin // tiny timeouts: expiry after a couple of ticks
          write_reg(REG_DEF_TIMEOUT, 16'd1);
          write_reg(REG_MAX_TIMEOUT, 16'd1);
          write_reg(REG_TICKS, 16'd1);
          write_reg(REG_VERSION, 16'd0);
        end
        1: begin
          write_reg(REG_DEF_TIMEOUT, 16'd255);
          write_reg(REG_MAX_TIMEOUT, 16'd255);
          write_reg(REG_TICKS, 16'hFFFF);
          write_reg(REG_VERSION, 16'hFF);
        end
        2: begin
          write_reg(REG_DEF_TIMEOUT, 16'd2);
          write_reg(REG_MAX_TIMEOUT, 16'd3);
          write_reg(REG_TICKS, 16'd2);
          write_reg(REG_VERSION, 16'h5A);
        end
        3: begin
          write_reg(REG_DEF_TIMEOUT, 16'($urandom_range(1, 255)));
          write_reg(REG_MAX_TIMEOUT, 16'($urandom_range(1, 255)));
          write_reg(REG_TICKS, 16'($urandom_range(1, 4)));
          write_reg(REG_VERSION, 16'($urandom_range(0, 255)));
        end
        default: begin
          write_reg(REG_DEF_TIMEOUT, 16'd30);
          write_reg(REG_MAX_TIMEOUT, 16'd4);
          write_reg(REG_TICKS, 16'd1);
          write_reg(REG_VERSION, 16'd1);
        end
      endcase
      gen_traffic(330);
      while (cmd_q.size() != 0) begin
        if (ph == 4 && cmd_q.size() < 120) quiet = 1'b1;
        c = cmd_q.pop_front();
        send_cmd(c, 1'b0, none);
      end
      settle(); // sender holds off until every reply is back
    end

    $display("checked %0d replies over 5 register settings", checked);
    $display("%0d frames completed, %0d idle expiries", frames_done, expiries);
    if (errors == 0 && reply_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d replies missing", errors, reply_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
